@@ rtl/core/rcr_pkg.sv @@
// rcr_pkg: widths, seed constants, step codes and the rotate helper
// shared by the rotation combined generator core; depends on nothing
`default_nettype none
package rcr_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 7;
    localparam int FRAC_W  = 53;
    localparam int SEED_W  = 32;
    localparam int ROUND_W = 12;

    localparam int MAX_BURST_DEF = 64;
    localparam int MANT_BITS_DEF = 53;

    localparam logic [WORD_W-1:0] INIT_X = 64'd914489;
    localparam logic [WORD_W-1:0] INIT_Y = 64'd8675416;
    localparam logic [WORD_W-1:0] INIT_Z = 64'd439754684;

    localparam logic [ROUND_W-1:0] WARMUP_BASE = 12'd20;

    typedef logic [1:0] step_t;

    localparam step_t STEP_X  = 2'd0;
    localparam step_t STEP_Y  = 2'd1;
    localparam step_t STEP_Z1 = 2'd2;
    localparam step_t STEP_Z2 = 2'd3;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rcr_step.sv @@
// rcr_step: shared rotate and add/subtract unit, one recurrence phase a cycle
// depends on rcr_pkg
`default_nettype none
module rcr_step (
    input  wire rcr_pkg::step_t              code,
    input  wire [rcr_pkg::WORD_W-1:0]        operand,
    output logic [rcr_pkg::WORD_W-1:0]       result
);

    logic [rcr_pkg::WORD_W-1:0] a;
    logic [rcr_pkg::WORD_W-1:0] b;
    logic                       sub;
    logic [rcr_pkg::WORD_W-1:0] sum;

    always_comb
    begin
        case (code)
            rcr_pkg::STEP_X:
            begin
                a   = rcr_pkg::rotl(operand, 8);
                b   = rcr_pkg::rotl(operand, 29);
                sub = 1'b1;
            end
            rcr_pkg::STEP_Y:
            begin
                a   = rcr_pkg::rotl(operand, 21);
                b   = operand;
                sub = 1'b1;
            end
            rcr_pkg::STEP_Z1:
            begin
                a   = rcr_pkg::rotl(operand, 42);
                b   = operand;
                sub = 1'b1;
            end
            default:
            begin
                a   = operand;
                b   = rcr_pkg::rotl(operand, 14);
                sub = 1'b0;
            end
        endcase
    end

    // single adder, subtract as add of the complement
    assign sum = a + (sub ? ~b : b) + {{(rcr_pkg::WORD_W-1){1'b0}}, sub};

    assign result = (code == rcr_pkg::STEP_Y) ? rcr_pkg::rotl(sum, 20) : sum;

endmodule
`default_nettype wire

@@ rtl/core/rotation_combined_rng.sv @@
// rotation_combined_rng: three rotate and add/subtract words stepped on one shared unit
// draw: each value runs the X, Y, Z1 and Z2 phases on the unit, then EMIT, which waits while out_ready is low
// reseed: INIT, then seed[31:22]+20 X rounds, seed[21:11]+20 Y rounds and seed[10:0]+20 Z1/Z2 rounds, in_ready low
// the single shared adder in rcr_step is reused by each phase, so the phases run one after another
// reset: seed cleared, then a seed-zero warm-up runs with in_ready low
// depends on rcr_pkg and rcr_step
`default_nettype none
module rotation_combined_rng #(
    parameter int MAX_BURST = rcr_pkg::MAX_BURST_DEF,
    parameter int MANT_BITS = rcr_pkg::MANT_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          seed_we,
    input  wire [rcr_pkg::SEED_W-1:0]    seed_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          op,
    input  wire [rcr_pkg::COUNT_W-1:0]   count,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [rcr_pkg::WORD_W-1:0]   raw_value,
    output logic [rcr_pkg::FRAC_W-1:0]   fraction,
    output logic                         last
);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_WX   = 4'd1;
    localparam logic [3:0] S_WY   = 4'd2;
    localparam logic [3:0] S_WZ1  = 4'd3;
    localparam logic [3:0] S_WZ2  = 4'd4;
    localparam logic [3:0] S_IDLE = 4'd5;
    localparam logic [3:0] S_DX   = 4'd6;
    localparam logic [3:0] S_DY   = 4'd7;
    localparam logic [3:0] S_DZ1  = 4'd8;
    localparam logic [3:0] S_DZ2  = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    localparam int CNT_MAX = (1 << rcr_pkg::COUNT_W) - 1;
    localparam int CNT_CAP = (MAX_BURST < CNT_MAX) ? MAX_BURST : CNT_MAX;
    localparam logic [rcr_pkg::WORD_W-1:0] MANT_MASK =
        (MANT_BITS >= rcr_pkg::WORD_W) ? {rcr_pkg::WORD_W{1'b1}}
                                       : ((64'd1 << MANT_BITS) - 64'd1);

    logic [3:0]                   state_reg, state_next;
    logic [rcr_pkg::SEED_W-1:0]   seed_reg;
    logic [rcr_pkg::SEED_W-1:0]   warm_seed_reg, warm_seed_next;
    logic [rcr_pkg::ROUND_W-1:0]  round_reg, round_next;
    logic [rcr_pkg::COUNT_W-1:0]  burst_reg, burst_next;
    logic [rcr_pkg::WORD_W-1:0]   word_x_reg, word_x_next;
    logic [rcr_pkg::WORD_W-1:0]   word_y_reg, word_y_next;
    logic [rcr_pkg::WORD_W-1:0]   word_z_reg, word_z_next;
    logic [rcr_pkg::WORD_W-1:0]   z1_reg, z1_next;
    logic                         out_valid_reg, out_valid_next;
    logic [rcr_pkg::WORD_W-1:0]   raw_reg, raw_next;
    logic                         last_reg, last_next;

    rcr_pkg::step_t               step_code;
    logic [rcr_pkg::WORD_W-1:0]   step_in;
    logic [rcr_pkg::WORD_W-1:0]   step_out;
    logic [rcr_pkg::COUNT_W-1:0]  count_sat;
    logic [rcr_pkg::ROUND_W-1:0]  rounds_y;
    logic [rcr_pkg::ROUND_W-1:0]  rounds_z;

    rcr_step u_step (
        .code    (step_code),
        .operand (step_in),
        .result  (step_out)
    );

    assign count_sat = (int'(count) > CNT_CAP) ? rcr_pkg::COUNT_W'(CNT_CAP) : count;
    assign rounds_y  = {1'b0, warm_seed_reg[21:11]} + rcr_pkg::WARMUP_BASE;
    assign rounds_z  = {1'b0, warm_seed_reg[10:0]} + rcr_pkg::WARMUP_BASE;

    always_comb
    begin
        case (state_reg)
            S_WX, S_DX:
            begin
                step_code = rcr_pkg::STEP_X;
                step_in   = word_x_reg;
            end
            S_WY, S_DY:
            begin
                step_code = rcr_pkg::STEP_Y;
                step_in   = word_y_reg;
            end
            S_WZ1, S_DZ1:
            begin
                step_code = rcr_pkg::STEP_Z1;
                step_in   = word_z_reg;
            end
            default:
            begin
                step_code = rcr_pkg::STEP_Z2;
                step_in   = z1_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        warm_seed_next = warm_seed_reg;
        round_next     = round_reg;
        burst_next     = burst_reg;
        word_x_next    = word_x_reg;
        word_y_next    = word_y_reg;
        word_z_next    = word_z_reg;
        z1_next        = z1_reg;
        raw_next       = raw_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_INIT:
            begin
                word_x_next = rcr_pkg::INIT_X;
                word_y_next = rcr_pkg::INIT_Y;
                word_z_next = rcr_pkg::INIT_Z;
                round_next  = {2'b00, warm_seed_reg[31:22]} + rcr_pkg::WARMUP_BASE;
                state_next  = S_WX;
            end
            S_WX:
            begin
                word_x_next = step_out;
                round_next  = round_reg - 1'b1;
                if (round_reg == 1)
                begin
                    round_next = rounds_y;
                    state_next = S_WY;
                end
            end
            S_WY:
            begin
                word_y_next = step_out;
                round_next  = round_reg - 1'b1;
                if (round_reg == 1)
                begin
                    round_next = rounds_z;
                    state_next = S_WZ1;
                end
            end
            S_WZ1:
            begin
                z1_next    = step_out;
                state_next = S_WZ2;
            end
            S_WZ2:
            begin
                word_z_next = step_out;
                round_next  = round_reg - 1'b1;
                state_next  = (round_reg == 1) ? S_IDLE : S_WZ1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!op)
                    begin
                        warm_seed_next = seed_reg;
                        state_next     = S_INIT;
                    end
                    else if (count_sat != '0)
                    begin
                        burst_next = count_sat;
                        state_next = S_DX;
                    end
                end
            end
            S_DX:
            begin
                word_x_next = step_out;
                state_next  = S_DY;
            end
            S_DY:
            begin
                word_y_next = step_out;
                state_next  = S_DZ1;
            end
            S_DZ1:
            begin
                z1_next    = step_out;
                state_next = S_DZ2;
            end
            S_DZ2:
            begin
                word_z_next = step_out;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                // load the output register once the previous transfer is gone
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    raw_next       = word_x_reg ^ word_y_reg ^ word_z_reg;
                    last_next      = (burst_reg == 1);
                    burst_next     = burst_reg - 1'b1;
                    state_next     = (burst_reg == 1) ? S_IDLE : S_DX;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            seed_reg      <= '0;
            warm_seed_reg <= '0;
            round_reg     <= '0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            warm_seed_reg <= warm_seed_next;
            round_reg     <= round_next;
            burst_reg     <= burst_next;
            out_valid_reg <= out_valid_next;
            if (seed_we)
            begin
                seed_reg <= seed_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_x_reg <= word_x_next;
        word_y_reg <= word_y_next;
        word_z_reg <= word_z_next;
        z1_reg     <= z1_next;
        raw_reg    <= raw_next;
        last_reg   <= last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign raw_value = raw_reg;
    assign fraction  = raw_reg[rcr_pkg::FRAC_W-1:0] & MANT_MASK[rcr_pkg::FRAC_W-1:0];
    assign last      = last_reg;

endmodule
`default_nettype wire
